FILE: rtl/gs3_pkg.sv
// ----------------------------------------------------------------------------
// gs3_pkg
// Shared types and constants of the 3x3 fixed-point linear solver.
// ----------------------------------------------------------------------------
package gs3_pkg;

	// Width of the external fixed-point fields
	localparam int IO_W = 32;

	// Pivot threshold register
	localparam int THRESH_W = 17;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd1;

	// One system A*s = b, signed Q16.16
	typedef struct packed {
		logic signed [IO_W-1:0] a00;
		logic signed [IO_W-1:0] a01;
		logic signed [IO_W-1:0] a02;
		logic signed [IO_W-1:0] a10;
		logic signed [IO_W-1:0] a11;
		logic signed [IO_W-1:0] a12;
		logic signed [IO_W-1:0] a20;
		logic signed [IO_W-1:0] a21;
		logic signed [IO_W-1:0] a22;
		logic signed [IO_W-1:0] b0;
		logic signed [IO_W-1:0] b1;
		logic signed [IO_W-1:0] b2;
	} in_item_t;

	// Solution and singular flag
	typedef struct packed {
		logic signed [IO_W-1:0] sol_x;
		logic signed [IO_W-1:0] sol_y;
		logic signed [IO_W-1:0] sol_z;
		logic                   singular;
	} out_item_t;

endpackage

FILE: rtl/gs3_div.sv
// ----------------------------------------------------------------------------
// gs3_div
// Pipelined fixed-point divider: (num * 2^F) / den, truncated toward zero and
// saturated to the word, one quotient bit per stage, with a side word that
// travels alongside.
// ----------------------------------------------------------------------------
module gs3_div #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16,
	parameter int SIDE_BITS     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [WORD_BITS-1:0] num,
	input  logic [WORD_BITS-1:0] den,
	input  logic [SIDE_BITS-1:0] side_in,
	output logic                 out_valid,
	output logic [WORD_BITS-1:0] quo,
	output logic                 dz,
	output logic [SIDE_BITS-1:0] side_out
);

	localparam int W = WORD_BITS;
	localparam int F = FRACTION_BITS;

	// magnitudes and overflow check of the entry stage
	logic [W-1:0] nm;
	logic [W-1:0] dm;
	logic         ovf_c;

	// quotient stages
	logic [W-1:0]     rem_s  [W+1];
	logic [W-1:0]     nlo_s  [W+1];
	logic [W-1:0]     q_s    [W+1];
	logic [W-1:0]     dm_s   [W+1];
	logic [SIDE_BITS-1:0] side_s [W+1];
	logic [W:0]       neg_s;
	logic [W:0]       ovf_s;
	logic [W:0]       dz_s;
	logic [W:0]       vld_s;

	// per-stage trial subtract
	logic [W-1:0] rem_nxt [W+1];
	logic [W:0]   ge;

	// result stage
	logic [W-1:0]         quo_c;
	logic [W-1:0]         res_quo_s;
	logic                 res_dz_s;
	logic [SIDE_BITS-1:0] res_side_s;
	logic                 res_vld_s;

	// Take magnitudes; flag quotients of 2^W or more
	always_comb begin
		nm = num[W-1] ? (~num + 1'b1) : num;
		dm = den[W-1] ? (~den + 1'b1) : den;
		ovf_c = {{(W-F){1'b0}}, nm, {F{1'b0}}} >= {dm, {W{1'b0}}};
	end

	// Shift in one numerator bit per stage, subtract when it fits
	always_comb begin
		rem_nxt[0] = '0;
		ge[0]      = 1'b0;
		for (int k = 1; k <= W; k++) begin
			logic [W:0] t;
			t = {rem_s[k-1], nlo_s[k-1][W-1]};
			ge[k] = t >= {1'b0, dm_s[k-1]};
			rem_nxt[k] = ge[k] ? W'(t - {1'b0, dm_s[k-1]}) : t[W-1:0];
		end
	end

	// Apply sign and saturate
	always_comb begin
		logic [W-1:0] lim;
		lim = {1'b1, {(W-1){1'b0}}};
		if (dz_s[W]) begin
			quo_c = '0;
		end else if (!neg_s[W]) begin
			quo_c = (ovf_s[W] || q_s[W] >= lim) ? (lim - 1'b1) : q_s[W];
		end else begin
			quo_c = (ovf_s[W] || q_s[W] >= lim) ? lim : (~q_s[W] + 1'b1);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			res_vld_s <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[W-1:0], in_valid};
			res_vld_s <= vld_s[W];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= W'(nm >> (W - F));
			nlo_s[0]  <= nm << F;
			q_s[0]    <= '0;
			dm_s[0]   <= dm;
			neg_s[0]  <= num[W-1] ^ den[W-1];
			ovf_s[0]  <= ovf_c;
			dz_s[0]   <= (dm == '0);
			side_s[0] <= side_in;
			for (int k = 1; k <= W; k++) begin
				rem_s[k]  <= rem_nxt[k];
				nlo_s[k]  <= nlo_s[k-1] << 1;
				q_s[k]    <= {q_s[k-1][W-2:0], ge[k]};
				dm_s[k]   <= dm_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				dz_s[k]   <= dz_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			res_quo_s  <= quo_c;
			res_dz_s   <= dz_s[W];
			res_side_s <= side_s[W];
		end
	end

	assign out_valid = res_vld_s;
	assign quo       = res_quo_s;
	assign dz        = res_dz_s;
	assign side_out  = res_side_s;

endmodule

FILE: rtl/gaussian_solve_3x3.sv
// ----------------------------------------------------------------------------
// gaussian_solve_3x3
// Solves one 3x3 fixed-point system per transfer by Gaussian elimination with
// threshold pivoting and back substitution; saturating arithmetic throughout.
//
//  channel | signals                             | transfer when
//  --------+-------------------------------------+-------------------------
//  input   | in_valid, in_ready, in_data         | in_valid && in_ready
//  output  | out_valid, out_ready, out_data      | out_valid && out_ready
//  config  | cfg_wr_en, cfg_wr_data              | cfg_wr_en
//
// One system enters per cycle while the pipeline advances. Five dividers lie
// in series on the path, each one quotient bit per stage.
// The whole pipeline advances while the output stage is empty or taken and
// holds otherwise. Reset clears valid bits and loads the threshold with 1.
// ----------------------------------------------------------------------------
module gaussian_solve_3x3 import gs3_pkg::*; #(
	parameter int FRACTION_BITS = 16,
	parameter int WORD_BITS     = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [THRESH_W-1:0] cfg_wr_data
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int XW = W + IO_W;
	localparam int PW = 2 * W;

	typedef logic [8:0][W-1:0] mat_t;
	typedef logic [2:0][W-1:0] vec_t;

	// Clamp a widened value into a word
	function automatic logic [W-1:0] clamp_w(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] hi;
		logic signed [XW-1:0] lo;
		hi = $signed({{(IO_W+1){1'b0}}, {(W-1){1'b1}}});
		lo = -hi - 1;
		if (v > hi) return hi[W-1:0];
		if (v < lo) return lo[W-1:0];
		return v[W-1:0];
	endfunction

	// Clamp a word into the external field width
	function automatic logic [IO_W-1:0] clamp_io(input logic signed [W-1:0] v);
		logic signed [XW-1:0] e;
		logic signed [XW-1:0] hi;
		logic signed [XW-1:0] lo;
		e  = XW'(v);
		hi = $signed({{(W+1){1'b0}}, {(IO_W-1){1'b1}}});
		lo = -hi - 1;
		if (e > hi) return hi[IO_W-1:0];
		if (e < lo) return lo[IO_W-1:0];
		return e[IO_W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic above(input logic signed [W-1:0] v,
			input logic [THRESH_W-1:0] th);
		return {{THRESH_W{1'b0}}, mag(v)} > {{W{1'b0}}, th};
	endfunction

	function automatic logic below(input logic signed [W-1:0] v,
			input logic [THRESH_W-1:0] th);
		return {{THRESH_W{1'b0}}, mag(v)} < {{W{1'b0}}, th};
	endfunction

	function automatic logic [W-1:0] sub_sat(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [XW-1:0] d;
		d = XW'(a) - XW'(b);
		return clamp_w(d);
	endfunction

	function automatic logic [PW-1:0] mul_mag(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return {{W{1'b0}}, mag(a)} * {{W{1'b0}}, mag(b)};
	endfunction

	// Drop fraction bits of a product magnitude, apply sign, saturate
	function automatic logic [W-1:0] prod_sat(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] r;
		logic [PW-1:0] lim;
		logic [PW-1:0] pmax;
		r    = p >> F;
		lim  = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
		pmax = lim - 1'b1;
		if (!neg) begin
			if (r >= lim) return pmax[W-1:0];
			return r[W-1:0];
		end
		if (r >= lim) return lim[W-1:0];
		return ~r[W-1:0] + 1'b1;
	endfunction

	logic [THRESH_W-1:0] thr_q;
	logic                adv;

	// stage 1: widen and pivot row 0
	mat_t fm, pm, m_s1;
	vec_t fv, pv, v_s1;
	logic vld_s1;

	// first elimination dividers
	logic         d1_vld, d1_dz, d1_e1, d2_vld, d2_dz, d2_e2;
	logic [W-1:0] d1_q, d2_q;
	mat_t         d1_m;
	vec_t         d1_v;

	// stage 2 and 3: products and updates of rows 1 and 2
	logic [5:0][PW-1:0] p_s2;
	logic [5:0]         neg_s2;
	mat_t               m_s2, m_s3, m3_c;
	vec_t               v_s2, v_s3, v3_c;
	logic               e1_s2, e2_s2, dz_s2, dz_s3, vld_s2, vld_s3;

	// second elimination divider
	logic         d3_vld, d3_dz, d3_e3, d3_dzin;
	logic [W-1:0] d3_q;
	mat_t         d3_m;
	vec_t         d3_v;

	// stage 4 and 5
	logic [1:0][PW-1:0] p_s4;
	logic [1:0]         neg_s4;
	mat_t               m_s4, m_s5, m5_c;
	vec_t               v_s4, v_s5, v5_c;
	logic               e3_s4, dz_s4, dz_s5, vld_s4, vld_s5;

	// z divider
	logic         d4_vld, d4_dz, d4_dzin;
	logic [W-1:0] d4_q, d4_m00, d4_m01, d4_m02, d4_m11, d4_m12, d4_v0, d4_v1;

	// stage 6 and 7
	logic [1:0][PW-1:0] p_s6;
	logic [1:0]         neg_s6;
	logic [W-1:0]       z_s6, m00_s6, m01_s6, m11_s6, v0_s6, v1_s6;
	logic [W-1:0]       t_s7, pz_s7, z_s7, m00_s7, m01_s7, m11_s7, v0_s7;
	logic               dz_s6, dz_s7, vld_s6, vld_s7;

	// y divider
	logic         d5_vld, d5_dz, d5_dzin;
	logic [W-1:0] d5_q, d5_m00, d5_m01, d5_v0, d5_pz, d5_z;

	// stage 8 to 10
	logic [PW-1:0] p_s8;
	logic          neg_s8;
	logic [W-1:0]  y_s8, m00_s8, v0_s8, pz_s8, z_s8;
	logic [W-1:0]  u_s9, m00_s9, pz_s9, y_s9, z_s9;
	logic [W-1:0]  w_s10, m00_s10, y_s10, z_s10;
	logic          dz_s8, dz_s9, dz_s10, vld_s8, vld_s9, vld_s10;

	// x divider
	logic         d6_vld, d6_dz, d6_dzin, d6_dzo;
	logic [W-1:0] d6_q, d6_y, d6_z;

	// stage 11: output register
	out_item_t out_s11;
	logic      vld_s11;

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Advance everything while the output stage is free or being taken
	assign adv      = !vld_s11 || out_ready;
	assign in_ready = adv;

	// Widen inputs and pick the leading row
	always_comb begin
		fm[0] = clamp_w(XW'(in_data.a00));
		fm[1] = clamp_w(XW'(in_data.a01));
		fm[2] = clamp_w(XW'(in_data.a02));
		fm[3] = clamp_w(XW'(in_data.a10));
		fm[4] = clamp_w(XW'(in_data.a11));
		fm[5] = clamp_w(XW'(in_data.a12));
		fm[6] = clamp_w(XW'(in_data.a20));
		fm[7] = clamp_w(XW'(in_data.a21));
		fm[8] = clamp_w(XW'(in_data.a22));
		fv[0] = clamp_w(XW'(in_data.b0));
		fv[1] = clamp_w(XW'(in_data.b1));
		fv[2] = clamp_w(XW'(in_data.b2));
		pm = fm;
		pv = fv;
		if (below(fm[0], thr_q)) begin
			if (above(fm[3], thr_q)) begin
				pm[2:0] = fm[5:3];
				pm[5:3] = fm[2:0];
				pv[0]   = fv[1];
				pv[1]   = fv[0];
			end else begin
				pm[2:0] = fm[8:6];
				pm[8:6] = fm[2:0];
				pv[0]   = fv[2];
				pv[2]   = fv[0];
			end
		end
	end

	// Update rows 1 and 2 where the step applies; eliminate row 2 or swap rows
	always_comb begin
		m3_c = m_s2;
		v3_c = v_s2;
		if (e1_s2) begin
			m3_c[4] = sub_sat(m_s2[4], prod_sat(p_s2[0], neg_s2[0]));
			m3_c[5] = sub_sat(m_s2[5], prod_sat(p_s2[1], neg_s2[1]));
			v3_c[1] = sub_sat(v_s2[1], prod_sat(p_s2[2], neg_s2[2]));
		end
		if (e2_s2) begin
			m3_c[7] = sub_sat(m_s2[7], prod_sat(p_s2[3], neg_s2[3]));
			m3_c[8] = sub_sat(m_s2[8], prod_sat(p_s2[4], neg_s2[4]));
			v3_c[2] = sub_sat(v_s2[2], prod_sat(p_s2[5], neg_s2[5]));
		end
		m5_c = m_s4;
		v5_c = v_s4;
		if (e3_s4) begin
			m5_c[8] = sub_sat(m_s4[8], prod_sat(p_s4[0], neg_s4[0]));
			v5_c[2] = sub_sat(v_s4[2], prod_sat(p_s4[1], neg_s4[1]));
		end else begin
			m5_c[5:3] = m_s4[8:6];
			m5_c[8:6] = m_s4[5:3];
			v5_c[1]   = v_s4[2];
			v5_c[2]   = v_s4[1];
		end
	end

	// Valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= d1_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= d3_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= d4_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= d5_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= d6_vld;
		end
	end

	// Multipliers for rows 1 and 2 against the first pivot
	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(1 + 12 * W)) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s1),
		.num(m_s1[3]), .den(m_s1[0]),
		.side_in({above(m_s1[3], thr_q), m_s1, v_s1}),
		.out_valid(d1_vld), .quo(d1_q), .dz(d1_dz), .side_out({d1_e1, d1_m, d1_v})
	);

	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(1)) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s1),
		.num(m_s1[6]), .den(m_s1[0]),
		.side_in(above(m_s1[6], thr_q)),
		.out_valid(d2_vld), .quo(d2_q), .dz(d2_dz), .side_out(d2_e2)
	);

	// Third divider: row 2 against the second pivot
	assign d3_dzin = dz_s3;
	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(2 + 12 * W)) u_div3 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s3),
		.num(m_s3[7]), .den(m_s3[4]),
		.side_in({above(m_s3[4], thr_q), d3_dzin, m_s3, v_s3}),
		.out_valid(d3_vld), .quo(d3_q), .dz(d3_dz), .side_out({d3_e3, d4_dzin, d3_m, d3_v})
	);

	// z = v2 / a22
	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(1 + 7 * W)) u_div4 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s5),
		.num(v_s5[2]), .den(m_s5[8]),
		.side_in({dz_s5, m_s5[0], m_s5[1], m_s5[2], m_s5[4], m_s5[5], v_s5[0], v_s5[1]}),
		.out_valid(d4_vld), .quo(d4_q), .dz(d4_dz),
		.side_out({d5_dzin, d4_m00, d4_m01, d4_m02, d4_m11, d4_m12, d4_v0, d4_v1})
	);

	// y = (v1 - a12*z) / a11
	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(1 + 5 * W)) u_div5 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s7),
		.num(t_s7), .den(m11_s7),
		.side_in({dz_s7, m00_s7, m01_s7, v0_s7, pz_s7, z_s7}),
		.out_valid(d5_vld), .quo(d5_q), .dz(d5_dz),
		.side_out({d6_dzin, d5_m00, d5_m01, d5_v0, d5_pz, d5_z})
	);

	// x = (v0 - a01*y - a02*z) / a00
	gs3_div #(.WORD_BITS(W), .FRACTION_BITS(F), .SIDE_BITS(1 + 2 * W)) u_div6 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_s10),
		.num(w_s10), .den(m00_s10),
		.side_in({dz_s10, y_s10, z_s10}),
		.out_valid(d6_vld), .quo(d6_q), .dz(d6_dz), .side_out({d6_dzo, d6_y, d6_z})
	);

	// Payload of the top-level stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			m_s1 <= pm;
			v_s1 <= pv;

			// stage 2: products for the first elimination
			p_s2[0]   <= mul_mag(d1_m[1], d1_q);
			p_s2[1]   <= mul_mag(d1_m[2], d1_q);
			p_s2[2]   <= mul_mag(d1_v[0], d1_q);
			p_s2[3]   <= mul_mag(d1_m[1], d2_q);
			p_s2[4]   <= mul_mag(d1_m[2], d2_q);
			p_s2[5]   <= mul_mag(d1_v[0], d2_q);
			neg_s2[0] <= d1_m[1][W-1] ^ d1_q[W-1];
			neg_s2[1] <= d1_m[2][W-1] ^ d1_q[W-1];
			neg_s2[2] <= d1_v[0][W-1] ^ d1_q[W-1];
			neg_s2[3] <= d1_m[1][W-1] ^ d2_q[W-1];
			neg_s2[4] <= d1_m[2][W-1] ^ d2_q[W-1];
			neg_s2[5] <= d1_v[0][W-1] ^ d2_q[W-1];
			m_s2  <= d1_m;
			v_s2  <= d1_v;
			e1_s2 <= d1_e1;
			e2_s2 <= d2_e2;
			dz_s2 <= (d1_dz && d1_e1) || (d2_dz && d2_e2);

			// stage 3: rows 1 and 2 after the first elimination
			m_s3  <= m3_c;
			v_s3  <= v3_c;
			dz_s3 <= dz_s2;

			// stage 4: products for the second elimination
			p_s4[0]   <= mul_mag(d3_m[5], d3_q);
			p_s4[1]   <= mul_mag(d3_v[1], d3_q);
			neg_s4[0] <= d3_m[5][W-1] ^ d3_q[W-1];
			neg_s4[1] <= d3_v[1][W-1] ^ d3_q[W-1];
			m_s4  <= d3_m;
			v_s4  <= d3_v;
			e3_s4 <= d3_e3;
			dz_s4 <= d4_dzin || (d3_dz && d3_e3);

			// stage 5: row 2 eliminated or rows 1 and 2 swapped
			m_s5  <= m5_c;
			v_s5  <= v5_c;
			dz_s5 <= dz_s4;

			// stage 6: products with z
			p_s6[0]   <= mul_mag(d4_m12, d4_q);
			p_s6[1]   <= mul_mag(d4_m02, d4_q);
			neg_s6[0] <= d4_m12[W-1] ^ d4_q[W-1];
			neg_s6[1] <= d4_m02[W-1] ^ d4_q[W-1];
			z_s6   <= d4_q;
			m00_s6 <= d4_m00;
			m01_s6 <= d4_m01;
			m11_s6 <= d4_m11;
			v0_s6  <= d4_v0;
			v1_s6  <= d4_v1;
			dz_s6  <= d5_dzin || d4_dz;

			// stage 7: numerator of y
			t_s7   <= sub_sat(v1_s6, prod_sat(p_s6[0], neg_s6[0]));
			pz_s7  <= prod_sat(p_s6[1], neg_s6[1]);
			z_s7   <= z_s6;
			m00_s7 <= m00_s6;
			m01_s7 <= m01_s6;
			m11_s7 <= m11_s6;
			v0_s7  <= v0_s6;
			dz_s7  <= dz_s6;

			// stage 8: product with y
			p_s8   <= mul_mag(d5_m01, d5_q);
			neg_s8 <= d5_m01[W-1] ^ d5_q[W-1];
			y_s8   <= d5_q;
			m00_s8 <= d5_m00;
			v0_s8  <= d5_v0;
			pz_s8  <= d5_pz;
			z_s8   <= d5_z;
			dz_s8  <= d6_dzin || d5_dz;

			// stage 9 and 10: numerator of x, in the order of the solve
			u_s9    <= sub_sat(v0_s8, prod_sat(p_s8, neg_s8));
			m00_s9  <= m00_s8;
			pz_s9   <= pz_s8;
			y_s9    <= y_s8;
			z_s9    <= z_s8;
			dz_s9   <= dz_s8;
			w_s10   <= sub_sat(u_s9, pz_s9);
			m00_s10 <= m00_s9;
			y_s10   <= y_s9;
			z_s10   <= z_s9;
			dz_s10  <= dz_s9;

			// stage 11: zero the solution of a singular system
			out_s11.singular <= d6_dzo || d6_dz;
			if (d6_dzo || d6_dz) begin
				out_s11.sol_x <= '0;
				out_s11.sol_y <= '0;
				out_s11.sol_z <= '0;
			end else begin
				out_s11.sol_x <= clamp_io(d6_q);
				out_s11.sol_y <= clamp_io(d6_y);
				out_s11.sol_z <= clamp_io(d6_z);
			end
		end
	end

	assign out_valid = vld_s11;
	assign out_data  = out_s11;

	// Both first-step divider lanes carry the same items
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		d1_vld == d2_vld)
		else $error("first elimination divider lanes out of step");

	// A singular system reports a zero solution
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
			out_data.sol_x == '0 && out_data.sol_y == '0 && out_data.sol_z == '0)
		else $error("singular result with nonzero solution");

	// Input only stalls behind a held result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a held result");

endmodule

FILE: tb/gaussian_solve_3x3_tb.sv
// ----------------------------------------------------------------------------
// gaussian_solve_3x3_tb
// Streams 3x3 fixed-point systems through the solver, predicts each solution
// with a saturating Q16.16 elimination model, and checks every output transfer
// against the oldest prediction under several idle and stall patterns.
// ----------------------------------------------------------------------------
module gaussian_solve_3x3_tb;
	import gs3_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 181;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_data;
	logic                cfg_wr_en;
	logic [THRESH_W-1:0] cfg_wr_data;

	out_item_t           solutions_due[$];
	logic [THRESH_W-1:0] thresh;
	int                  send_idle_pct;
	int                  stall_pct;
	int                  errors;

	gaussian_solve_3x3 uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Saturate to a 32-bit signed word
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint magn(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Product truncated toward zero, saturated
	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		longint m;
		p = 128'(magn(a)) * 128'(magn(b));
		p = p >> FRAC;
		m = (p > 128'd2147483648) ? 64'sd2147483648 : longint'(p[63:0]);
		return clamp32(((a < 0) != (b < 0)) ? -m : m);
	endfunction

	// Quotient truncated toward zero, saturated; zero divisor flags singular
	function automatic longint qdiv(longint n, longint d, inout bit dz);
		logic [127:0] q;
		longint m;
		if (d == 0) begin
			dz = 1'b1;
			return 0;
		end
		q = (128'(magn(n)) << FRAC) / 128'(magn(d));
		m = (q > 128'd2147483648) ? 64'sd2147483648 : longint'(q[63:0]);
		return clamp32(((n < 0) != (d < 0)) ? -m : m);
	endfunction

	function automatic longint qsub(longint a, longint b);
		return clamp32(a - b);
	endfunction

	function automatic void row_swap(inout longint m[3][3], inout longint v[3],
			input int r, input int s);
		longint t;
		for (int c = 0; c < 3; c++) begin
			t = m[r][c]; m[r][c] = m[s][c]; m[s][c] = t;
		end
		t = v[r]; v[r] = v[s]; v[s] = t;
	endfunction

	function automatic void clear_entry(inout longint m[3][3], inout longint v[3],
			input int piv, input int row, input int col, inout bit dz);
		longint f;
		f = qdiv(m[row][col], m[piv][col], dz);
		m[row][col] = 0;
		for (int c = col + 1; c < 3; c++)
			m[row][c] = qsub(m[row][c], qmul(m[piv][c], f));
		v[row] = qsub(v[row], qmul(v[piv], f));
	endfunction

	// Solve one system the way the block should
	function automatic out_item_t solve_system(in_item_t s, logic [THRESH_W-1:0] th);
		longint m[3][3];
		longint v[3];
		longint x, y, z, t;
		bit dz;
		out_item_t r;
		t = longint'(th);
		dz = 1'b0;
		m[0][0] = s.a00; m[0][1] = s.a01; m[0][2] = s.a02;
		m[1][0] = s.a10; m[1][1] = s.a11; m[1][2] = s.a12;
		m[2][0] = s.a20; m[2][1] = s.a21; m[2][2] = s.a22;
		v[0] = s.b0; v[1] = s.b1; v[2] = s.b2;
		if (magn(m[0][0]) < t) begin
			if (magn(m[1][0]) > t) row_swap(m, v, 0, 1);
			else row_swap(m, v, 0, 2);
		end
		if (magn(m[1][0]) > t) clear_entry(m, v, 0, 1, 0, dz);
		if (magn(m[2][0]) > t) clear_entry(m, v, 0, 2, 0, dz);
		if (magn(m[1][1]) > t) clear_entry(m, v, 1, 2, 1, dz);
		else row_swap(m, v, 1, 2);
		z = qdiv(v[2], m[2][2], dz);
		y = qdiv(qsub(v[1], qmul(m[1][2], z)), m[1][1], dz);
		x = qdiv(qsub(qsub(v[0], qmul(m[0][1], y)), qmul(m[0][2], z)), m[0][0], dz);
		if (dz) begin
			x = 0; y = 0; z = 0;
		end
		r.sol_x = x[31:0];
		r.sol_y = y[31:0];
		r.sol_z = z[31:0];
		r.singular = dz;
		return r;
	endfunction

	// Send one system; hold valid and payload until the transfer.
	// Valid drops only while idling or once sending stops.
	task automatic send_system(in_item_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		solutions_due.push_back(solve_system(s, thresh));
		do @(posedge clk); while (!in_ready);
	endtask

	// Drain, then let the pipeline settle before touching the register
	task automatic drain_and_write(logic [THRESH_W-1:0] th);
		in_valid <= 1'b0;
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= th;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thresh = th;
	endtask

	function automatic logic [31:0] rand_coeff();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'($signed($urandom_range(6)) - 3);
			4: return 32'($signed($urandom_range(131072)) - 65536);
			5, 6: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_system();
		in_item_t s;
		s.a00 = rand_coeff(); s.a01 = rand_coeff(); s.a02 = rand_coeff();
		s.a10 = rand_coeff(); s.a11 = rand_coeff(); s.a12 = rand_coeff();
		s.a20 = rand_coeff(); s.a21 = rand_coeff(); s.a22 = rand_coeff();
		s.b0 = rand_coeff(); s.b1 = rand_coeff(); s.b2 = rand_coeff();
		return s;
	endfunction

	function automatic in_item_t make_system(int a00, int a01, int a02, int a10,
			int a11, int a12, int a20, int a21, int a22, int b0, int b1, int b2);
		in_item_t s;
		s.a00 = a00; s.a01 = a01; s.a02 = a02;
		s.a10 = a10; s.a11 = a11; s.a12 = a12;
		s.a20 = a20; s.a21 = a21; s.a22 = a22;
		s.b0 = b0; s.b1 = b1; s.b2 = b2;
		return s;
	endfunction

	// Directed: identity, pivot swaps, singular and saturating cases
	task automatic test_directed();
		localparam int ONE = 65536;
		in_item_t s;
		send_system(make_system(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, -ONE, 3 * ONE));
		send_system(make_system(2 * ONE, ONE, -ONE, -3 * ONE, -ONE, 2 * ONE,
			-2 * ONE, ONE, 2 * ONE, 8 * ONE, -11 * ONE, -3 * ONE));
		// small leading pivot, swap with row 1
		send_system(make_system(0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 5, 7, 9));
		// small leading pivot and row 1, fallback to row 2 still zero
		send_system(make_system(0, ONE, 2, 0, ONE, 0, 0, 3, ONE, ONE, ONE, ONE));
		// fallback to row 2 with a usable pivot
		send_system(make_system(0, ONE, 0, 0, 0, ONE, ONE, 0, 0, 1, 2, 3));
		// small second pivot, rows 1 and 2 swapped
		send_system(make_system(ONE, ONE, ONE, ONE, ONE, 2 * ONE, ONE, 2 * ONE, ONE,
			ONE, ONE, ONE));
		// all zero: singular
		send_system(make_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// extremes to force saturation
		send_system(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1,
			32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_system(make_system(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, -1));
		send_system(make_system(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		s = '1;
		send_system(s);
	endtask

	// Random systems under the current idle pattern and threshold
	task automatic test_random(int count, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) send_system(rand_system());
	endtask

	// Hold off the sender until the pipeline has fully emptied
	task automatic test_pause_to_empty();
		for (int i = 0; i < 20; i++) send_system(rand_system());
		in_valid <= 1'b0;
		while (solutions_due.size() != 0) @(posedge clk);
		for (int i = 0; i < 20; i++) send_system(rand_system());
	endtask

	// Receiver stalls at random; the stall percentage changes by phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_sol;
		if (arst_n && out_valid && out_ready) begin
			if (solutions_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_sol = solutions_due.pop_front();
				if (out_data.sol_x !== exp_sol.sol_x) begin
					$display("%0t: sol_x expected %h actual %h", $time,
						exp_sol.sol_x, out_data.sol_x);
					errors++;
				end
				if (out_data.sol_y !== exp_sol.sol_y) begin
					$display("%0t: sol_y expected %h actual %h", $time,
						exp_sol.sol_y, out_data.sol_y);
					errors++;
				end
				if (out_data.sol_z !== exp_sol.sol_z) begin
					$display("%0t: sol_z expected %h actual %h", $time,
						exp_sol.sol_z, out_data.sol_z);
					errors++;
				end
				if (out_data.singular !== exp_sol.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						exp_sol.singular, out_data.singular);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		out_ready = 1'b0;
		thresh = THRESH_RESET;
		send_idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 0, 0);
		test_pause_to_empty();
		drain_and_write(17'd0);
		test_directed();
		test_random(250, 81, 0);
		drain_and_write(17'h1ffff);
		test_directed();
		test_random(250, 0, 81);
		drain_and_write(17'd65536);
		test_random(250, 16, 16);
		drain_and_write(17'd300);
		test_random(250, 0, 0);
		drain_and_write(17'($urandom_range(65536)));
		test_random(250, 16, 16);
		drain_and_write(17'h0aaaa);
		test_random(200, 0, 0);

		// wait for the tail of the pipeline
		in_valid <= 1'b0;
		while (solutions_due.size() != 0) @(posedge clk);
		stall_pct = 0;
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
